// ===== rtl/cfmu_pkg.sv =====
package cfmu_pkg;

	localparam int COORD_W = 32;
	localparam int MAG_W   = 64;
	localparam int UV_W    = 17;
	localparam int Q_W     = 16;
	localparam int DIR_W   = 6;
	localparam int FACE_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STAGES = Q_W;

	localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_Z = 2'd2;

	localparam logic [31:0] INV_HALF_RESET = 32'd65536;

	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

	localparam logic [UV_W-1:0] HALF_Q16 = 17'd32768;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [MAG_W-1:0] az;
		logic             px;
		logic             py;
		logic             pz;
	} scaled_t;

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [MAG_W-1:0]  m;
		logic [MAG_W-1:0]  umag;
		logic [MAG_W-1:0]  vmag;
		logic              upos;
		logic              vpos;
		logic              origin;
	} sel_t;

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [MAG_W-1:0]  m;
		logic [MAG_W:0]    ur;
		logic [MAG_W:0]    vr;
		logic [Q_W-1:0]    uq;
		logic [Q_W-1:0]    vq;
		logic              upos;
		logic              vpos;
		logic              origin;
	} div_t;

	// Rows: tangent, bitangent, normal; 2-bit components, x in bits 1:0.
	function automatic logic [3*DIR_W-1:0] frame_row(input logic [FACE_W-1:0] f);
		logic [3*DIR_W-1:0] r;
		case (f)
			FACE_NEG_X: r = {6'h10, 6'h04, 6'h03};
			FACE_POS_X: r = {6'h30, 6'h04, 6'h01};
			FACE_NEG_Y: r = {6'h01, 6'h10, 6'h0C};
			FACE_POS_Y: r = {6'h01, 6'h30, 6'h04};
			FACE_NEG_Z: r = {6'h03, 6'h04, 6'h30};
			FACE_POS_Z: r = {6'h01, 6'h04, 6'h10};
			default:    r = {6'h10, 6'h04, 6'h03};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/cfmu_if.sv =====
interface cfmu_pt_if;
	import cfmu_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface cfmu_res_if;
	import cfmu_pkg::*;
	logic              valid;
	logic              ready;
	logic [FACE_W-1:0] face;
	logic [UV_W-1:0]   tex_u;
	logic [UV_W-1:0]   tex_v;
	logic [DIR_W-1:0]  tangent_dir;
	logic [DIR_W-1:0]  bitangent_dir;
	logic [DIR_W-1:0]  normal_dir;
	logic              origin_hit;
	modport source(output valid, face, tex_u, tex_v, tangent_dir, bitangent_dir,
		normal_dir, origin_hit, input ready);
	modport sink(input valid, face, tex_u, tex_v, tangent_dir, bitangent_dir,
		normal_dir, origin_hit, output ready);
endinterface

// ===== rtl/cfmu_scale.sv =====
module cfmu_scale import cfmu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] x,
	input  logic signed [COORD_W-1:0] y,
	input  logic signed [COORD_W-1:0] z,
	input  logic [31:0]               inv_x,
	input  logic [31:0]               inv_y,
	input  logic [31:0]               inv_z,
	output logic                      valid_s1,
	output scaled_t                   data_s1
);
	logic [COORD_W-1:0] mx, my, mz;
	scaled_t nxt;

	// The magnitude of the most negative value still fits 32 unsigned bits.
	assign mx = x[COORD_W-1] ? (~x + 1'b1) : x;
	assign my = y[COORD_W-1] ? (~y + 1'b1) : y;
	assign mz = z[COORD_W-1] ? (~z + 1'b1) : z;

	always_comb begin
		nxt.ax = {32'd0, mx} * {32'd0, inv_x};
		nxt.ay = {32'd0, my} * {32'd0, inv_y};
		nxt.az = {32'd0, mz} * {32'd0, inv_z};
		nxt.px = !x[COORD_W-1] && (nxt.ax != '0);
		nxt.py = !y[COORD_W-1] && (nxt.ay != '0);
		nxt.pz = !z[COORD_W-1] && (nxt.az != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end
endmodule

// ===== rtl/cfmu_select.sv =====
module cfmu_select import cfmu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    valid_s1,
	input  scaled_t data_s1,
	output logic    valid_s2,
	output sel_t    data_s2
);
	sel_t nxt;
	logic x_dom, y_dom;

	assign x_dom = (data_s1.ax >= data_s1.ay) && (data_s1.ax >= data_s1.az);
	assign y_dom = (data_s1.ay >= data_s1.ax) && (data_s1.ay >= data_s1.az);

	always_comb begin
		if (x_dom) begin
			nxt.face = data_s1.px ? FACE_POS_X : FACE_NEG_X;
			nxt.m    = data_s1.ax;
			nxt.umag = data_s1.az;
			nxt.upos = data_s1.px ? (!data_s1.pz && data_s1.az != '0) : data_s1.pz;
			nxt.vmag = data_s1.ay;
			nxt.vpos = data_s1.py;
		end else if (y_dom) begin
			nxt.face = data_s1.py ? FACE_POS_Y : FACE_NEG_Y;
			nxt.m    = data_s1.ay;
			nxt.umag = data_s1.ax;
			nxt.upos = data_s1.px;
			nxt.vmag = data_s1.az;
			nxt.vpos = data_s1.py ? (!data_s1.pz && data_s1.az != '0) : data_s1.pz;
		end else begin
			nxt.face = data_s1.pz ? FACE_POS_Z : FACE_NEG_Z;
			nxt.m    = data_s1.az;
			nxt.umag = data_s1.ax;
			nxt.upos = data_s1.pz ? data_s1.px : (!data_s1.px && data_s1.ax != '0);
			nxt.vmag = data_s1.ay;
			nxt.vpos = data_s1.py;
		end
		nxt.origin = (nxt.m == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end
endmodule

// ===== rtl/cfmu_div.sv =====
module cfmu_div import cfmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s2,
	input  sel_t data_s2,
	output logic valid_out,
	output div_t data_out
);
	div_t div_s [DIV_STAGES];
	logic vld_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		div_t prev, nxt;
		logic prev_v;
		logic [MAG_W:0] ush, vsh;
		logic uge, vge;

		if (k == 0) begin : g_first
			always_comb begin
				prev.face   = data_s2.face;
				prev.m      = data_s2.m;
				prev.ur     = {1'b0, data_s2.umag};
				prev.vr     = {1'b0, data_s2.vmag};
				prev.uq     = '0;
				prev.vq     = '0;
				prev.upos   = data_s2.upos;
				prev.vpos   = data_s2.vpos;
				prev.origin = data_s2.origin;
			end
			assign prev_v = valid_s2;
			assign ush = prev.ur;
			assign vsh = prev.vr;
		end else begin : g_next
			assign prev   = div_s[k-1];
			assign prev_v = vld_s[k-1];
			// After the first step the remainder stays below the divisor, so
			// the doubled value fits one extra bit.
			assign ush = {prev.ur[MAG_W-1:0], 1'b0};
			assign vsh = {prev.vr[MAG_W-1:0], 1'b0};
		end

		assign uge = ush >= {1'b0, prev.m};
		assign vge = vsh >= {1'b0, prev.m};

		always_comb begin
			nxt    = prev;
			nxt.ur = uge ? (ush - {1'b0, prev.m}) : ush;
			nxt.vr = vge ? (vsh - {1'b0, prev.m}) : vsh;
			nxt.uq = {prev.uq[Q_W-2:0], uge};
			nxt.vq = {prev.vq[Q_W-2:0], vge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt;
			end
		end
	end

	assign valid_out = vld_s[DIV_STAGES-1];
	assign data_out  = div_s[DIV_STAGES-1];
endmodule

// ===== rtl/cube_face_uv_mapper.sv =====
// Cube face and texture coordinate mapper. One hit point is accepted in every
// cycle while results are taken; its result passes through one stage of three
// 32x32 scaling multipliers, one stage of dominant-axis selection, sixteen
// restoring division stages (one quotient bit each, u and v side by side) and
// one output register. A stall on the result side holds the whole pipeline.
// The user must write the inverse half-size registers through the cfg port
// only while no transaction is in flight; the block does not enforce it.
module cube_face_uv_mapper import cfmu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	cfmu_pt_if.sink              pt,
	cfmu_res_if.source           res
);
	logic [31:0] inv_x_q, inv_y_q, inv_z_q;
	logic        en;
	logic        valid_s1, valid_s2, valid_dv;
	scaled_t     data_s1;
	sel_t        data_s2;
	div_t        data_dv;
	logic [Q_W:0]       uqc, vqc;
	logic [3*DIR_W-1:0] frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= INV_HALF_RESET;
			inv_y_q <= INV_HALF_RESET;
			inv_z_q <= INV_HALF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_HALF_X: inv_x_q <= cfg_data;
				REG_INV_HALF_Y: inv_y_q <= cfg_data;
				REG_INV_HALF_Z: inv_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !res.valid || res.ready;
	assign pt.ready = en;

	cfmu_scale u_scale (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pt.valid),
		.x(pt.point_x), .y(pt.point_y), .z(pt.point_z),
		.inv_x(inv_x_q), .inv_y(inv_y_q), .inv_z(inv_z_q),
		.valid_s1(valid_s1), .data_s1(data_s1)
	);

	cfmu_select u_select (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_s1(valid_s1), .data_s1(data_s1),
		.valid_s2(valid_s2), .data_s2(data_s2)
	);

	cfmu_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_s2(valid_s2), .data_s2(data_s2),
		.valid_out(valid_dv), .data_out(data_dv)
	);

	assign uqc = ({1'b0, data_dv.uq} > HALF_Q16) ? HALF_Q16 : {1'b0, data_dv.uq};
	assign vqc = ({1'b0, data_dv.vq} > HALF_Q16) ? HALF_Q16 : {1'b0, data_dv.vq};
	assign frame = frame_row(data_dv.face);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (en) begin
			res.valid <= valid_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.face          <= data_dv.face;
			res.origin_hit    <= data_dv.origin;
			res.tangent_dir   <= frame[3*DIR_W-1:2*DIR_W];
			res.bitangent_dir <= frame[2*DIR_W-1:DIR_W];
			res.normal_dir    <= frame[DIR_W-1:0];
			if (data_dv.origin) begin
				res.tex_u <= HALF_Q16;
				res.tex_v <= HALF_Q16;
			end else begin
				res.tex_u <= data_dv.upos ? (HALF_Q16 + uqc) : (HALF_Q16 - uqc);
				res.tex_v <= data_dv.vpos ? (HALF_Q16 + vqc) : (HALF_Q16 - vqc);
			end
		end
	end

`ifndef ASSERT_OFF
	a_origin_uv: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.origin_hit |-> res.tex_u == HALF_Q16 && res.tex_v == HALF_Q16)
		else $error("origin result without centred uv");
	a_origin_face: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.origin_hit |-> res.face == FACE_NEG_X)
		else $error("origin result not on the -X face");
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.face <= FACE_POS_Z && res.tex_u <= 2 * HALF_Q16
		&& res.tex_v <= 2 * HALF_Q16)
		else $error("result face or uv out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> !pt.ready || res.valid)
		else $error("pipeline advanced during a stall");
`endif
endmodule
